// ===== hdl/lsk_pkg.sv =====
package lsk_pkg;

    // Array and element limits.
    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_BITS   = 16;
    localparam int TABLE_SLOTS  = 2048;

    // Field widths.
    localparam int SUM_W  = 26;
    localparam int KEY_W  = SUM_W + 1;
    localparam int BEST_W = 11;
    localparam int POS_W  = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

    // Stream widths, padded to whole bytes.
    localparam int IN_DATA_W  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((BEST_W + 7) / 8) * 8;

    // One array never inserts more prefixes than it has elements, so the
    // chain needs no more cells than the smaller of the two limits.
    localparam int NUM_CELLS = (MAX_ELEMENTS < TABLE_SLOTS) ? MAX_ELEMENTS : TABLE_SLOTS;

    // Token that carries one element down the chain of cells.
    typedef struct packed {
        logic             valid;    // token holds an element
        logic             last;     // final element of the array
        logic             active;   // element was within capacity
        logic             eq;       // running sum equals the target
        logic             placed;   // prefix already stored or just inserted
        logic             hit;      // a stored prefix matched sum minus target
        logic [SUM_W-1:0] sum;      // running sum after this element
        logic [KEY_W-1:0] lkey;     // sum minus target, without wrap
        logic [POS_W-1:0] pos;      // position of this element
        logic [POS_W-1:0] hit_pos;  // first position of the matching prefix
    } lsk_token_t;

endpackage

// ===== hdl/lsk_front.sv =====
module lsk_front
    import lsk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [SUM_W-1:0]      cfg_wr_data,
    input  logic                  advance,
    input  logic                  in_valid,
    input  logic [VALUE_BITS-1:0] element_value,
    input  logic                  is_last,
    output lsk_token_t            tok_out
);

    logic [SUM_W-1:0] target_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    lsk_token_t       tok_reg;
    lsk_token_t       tok_next;
    logic             accept;
    logic             active;
    logic [SUM_W-1:0] sum_new;
    logic [KEY_W-1:0] lkey;

    assign accept  = in_valid && advance;
    assign active  = (cnt_reg < CNT_W'(MAX_ELEMENTS));
    assign sum_new = sum_reg + {{(SUM_W - VALUE_BITS){element_value[VALUE_BITS-1]}},
                                element_value};
    assign lkey    = {sum_new[SUM_W-1], sum_new} - {target_reg[SUM_W-1], target_reg};

    // Target register; the user must write it only while the block is idle, as the block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            target_reg <= cfg_wr_data;
        end
    end

    // Running sum, position count and the token sent into the chain.
    always_comb
    begin
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        tok_next       = tok_reg;
        tok_next.valid = 1'b0;
        if (accept)
        begin
            tok_next.valid   = 1'b1;
            tok_next.last    = is_last;
            tok_next.active  = active;
            tok_next.eq      = active && (sum_new == target_reg);
            tok_next.placed  = 1'b0;
            tok_next.hit     = 1'b0;
            tok_next.sum     = sum_new;
            tok_next.lkey    = lkey;
            tok_next.pos     = cnt_reg[POS_W-1:0];
            tok_next.hit_pos = '0;
            if (active)
            begin
                sum_next = sum_new;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            if (is_last)
            begin
                sum_next = '0;
                cnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
            tok_reg <= '0;
        end
        else if (advance)
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

`ifndef SYNTHESIS
    // The position count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("position count beyond capacity");
`endif

endmodule

// ===== hdl/lsk_cell.sv =====
module lsk_cell
    import lsk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  lsk_token_t tok_in,
    output lsk_token_t tok_out
);

    logic             slot_valid_reg;
    logic             slot_valid_next;
    logic [SUM_W-1:0] key_reg;
    logic [SUM_W-1:0] key_next;
    logic [POS_W-1:0] first_pos_reg;
    logic [POS_W-1:0] first_pos_next;
    lsk_token_t       tok_reg;
    lsk_token_t       tok_next;
    logic             key_hit;
    logic             key_same;
    logic             clear_now;

    assign key_hit   = slot_valid_reg && ({key_reg[SUM_W-1], key_reg} == tok_in.lkey);
    assign key_same  = slot_valid_reg && (key_reg == tok_in.sum);
    assign clear_now = advance && tok_in.valid && tok_in.last;

    // Lookup against the stored prefix, then insert into the first free cell.
    always_comb
    begin
        tok_next        = tok_in;
        slot_valid_next = slot_valid_reg;
        key_next        = key_reg;
        first_pos_next  = first_pos_reg;
        if (tok_in.valid && tok_in.active)
        begin
            if (key_hit)
            begin
                tok_next.hit     = 1'b1;
                tok_next.hit_pos = first_pos_reg;
            end
            if (!tok_in.placed)
            begin
                if (key_same)
                begin
                    tok_next.placed = 1'b1;
                end
                else if (!slot_valid_reg)
                begin
                    slot_valid_next = 1'b1;
                    key_next        = tok_in.sum;
                    first_pos_next  = tok_in.pos;
                    tok_next.placed = 1'b1;
                end
            end
        end
        // The last element of an array empties every cell it passes.
        if (tok_in.valid && tok_in.last)
        begin
            slot_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            tok_reg        <= '0;
        end
        else if (advance)
        begin
            slot_valid_reg <= slot_valid_next;
            tok_reg        <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_reg       <= key_next;
            first_pos_reg <= first_pos_next;
        end
    end

    assign tok_out = tok_reg;

`ifndef SYNTHESIS
    // A last element leaves the cell empty behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_now |=> !slot_valid_reg)
        else $error("cell not cleared after last element");

    // A stored prefix keeps its key and first position until the array ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        slot_valid_reg && !clear_now |=>
            slot_valid_reg && $stable(key_reg) && $stable(first_pos_reg))
        else $error("stored prefix changed");
`endif

endmodule

// ===== hdl/lsk_back.sv =====
module lsk_back
    import lsk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lsk_token_t        tok_in,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BEST_W-1:0] best_length,
    output logic              array_done,
    output logic              capacity_overflow
);

    logic [CNT_W-1:0]  longest_reg;
    logic [CNT_W-1:0]  longest_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BEST_W-1:0] out_best_reg;
    logic              out_last_reg;
    logic              out_ovf_reg;
    logic [CNT_W-1:0]  len_eq;
    logic [CNT_W-1:0]  len_hit;
    logic [CNT_W-1:0]  best_a;
    logic [CNT_W-1:0]  best;
    logic              ovf_new;
    logic              take;

    // The chain moves whenever the output register can take a beat.
    assign advance = !out_valid_reg || out_ready;
    assign take    = advance && tok_in.valid;

    // Candidate lengths from the target match and the prefix match.
    assign len_eq  = tok_in.eq ? CNT_W'(tok_in.pos) + CNT_W'(1) : '0;
    assign len_hit = tok_in.hit ? CNT_W'(tok_in.pos - tok_in.hit_pos) : '0;
    assign best_a  = (len_eq > longest_reg) ? len_eq : longest_reg;
    assign best    = (len_hit > best_a) ? len_hit : best_a;
    assign ovf_new = ovf_reg || !tok_in.active || !tok_in.placed;

    // Running best and overflow flag, cleared after the last element.
    always_comb
    begin
        longest_next   = longest_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = tok_in.valid;
        end
        if (take)
        begin
            longest_next = tok_in.last ? '0 : best;
            ovf_next     = tok_in.last ? 1'b0 : ovf_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            longest_reg   <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            longest_reg   <= longest_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_best_reg <= BEST_W'(best);
            out_last_reg <= tok_in.last;
            out_ovf_reg  <= ovf_new;
        end
    end

    assign out_valid         = out_valid_reg;
    assign best_length       = out_best_reg;
    assign array_done        = out_last_reg;
    assign capacity_overflow = out_ovf_reg;

`ifndef SYNTHESIS
    // Within one array the best length never shrinks.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && !tok_in.last |=> longest_reg >= $past(longest_reg))
        else $error("best length decreased within an array");

    // The beat that ends an array leaves the running state cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        take && tok_in.last |=> longest_reg == '0 && !ovf_reg)
        else $error("array state not cleared after last element");
`endif

endmodule

// ===== hdl/longest_subarray_sum_k_unit.sv =====
// Channel   Direction  Payload
// cfg       in         cfg_wr_data = target_sum (signed, 26 bits)
// s_axis    in         tdata = element_value, tlast = is_last
// m_axis    out        tdata = best_length, tlast = array_done,
//                      tuser = capacity_overflow
//
// One beat enters per cycle while m_axis does not stall; each result is presented on
// m_axis once its accepted element beat has passed the input register, the chain of
// prefix cells and the output register.
// Reset clears all cells at once; there is no clearing pass.
// The last element of an array empties each cell as it passes it.
// A stall on m_axis freezes the whole chain and holds s_axis_tready low.
module longest_subarray_sum_k_unit
    import lsk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [SUM_W-1:0]      cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] element_value
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [10:0] best_length, rest zero
    output logic                  m_axis_tlast,
    output logic [0:0]            m_axis_tuser    // [0] capacity_overflow
);

    lsk_token_t        tok_chain [NUM_CELLS+1];
    logic              advance;
    logic [BEST_W-1:0] best_length;

    // Input stage: running sum, position and target compare.
    lsk_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .advance       (advance),
        .in_valid      (s_axis_tvalid),
        .element_value (s_axis_tdata[VALUE_BITS-1:0]),
        .is_last       (s_axis_tlast),
        .tok_out       (tok_chain[0])
    );

    // Chain of prefix cells, each holding one stored prefix.
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        lsk_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1])
        );
    end

    // Output stage: running best length and overflow flag.
    lsk_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .tok_in            (tok_chain[NUM_CELLS]),
        .advance           (advance),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .best_length       (best_length),
        .array_done        (m_axis_tlast),
        .capacity_overflow (m_axis_tuser[0])
    );

    assign s_axis_tready = advance;
    assign m_axis_tdata  = {{(OUT_DATA_W - BEST_W){1'b0}}, best_length};

endmodule

// ===== verif/longest_subarray_sum_k_unit_test.sv =====
`timescale 1ns / 100ps

module longest_subarray_sum_k_unit_test;

    import lsk_pkg::*;

    localparam int LATENCY_CYCLES   = NUM_CELLS + 1;
    localparam int WATCHDOG_LIMIT   = 6000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS      = 40;

    // Element draw styles: small values make repeated prefixes and matches likely.
    typedef enum int {
        DRAW_SMALL,
        DRAW_MEDIUM,
        DRAW_FULL
    } draw_mode_t;

    typedef struct packed {
        logic [BEST_W-1:0] best;
        logic              done;
        logic              overflow;
    } length_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [SUM_W-1:0]      cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;    // [15:0] element_value
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [10:0] best_length, rest zero
    logic                  m_axis_tlast;
    logic [0:0]            m_axis_tuser;         // [0] capacity_overflow

    // Shared control between the stimulus and the result side.
    bit idle_enable = 1'b0;
    int hold_seq    = 0;
    int hold_seen   = 0;
    int stall_left  = 0;
    int quiet_cycles = 0;
    int mismatch_count = 0;

    // Expected results, oldest first.
    length_result_t expected_lengths[$];

    // Predictor state for the array in progress.
    logic signed [SUM_W-1:0] target_k = '0;
    logic signed [SUM_W-1:0] prefix_sum = '0;
    int unsigned             element_pos = 0;
    int unsigned             longest = 0;
    bit                      overflow_flag = 1'b0;
    int unsigned             first_seen[longint];

    longest_subarray_sum_k_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 20 ns clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Advance the prefix-sum predictor by one element and return its result.
    function automatic length_result_t predict_longest(
        input logic signed [VALUE_BITS-1:0] value,
        input bit                           last_flag
    );
        length_result_t res;
        longint         lookup_key;
        int unsigned    pos;
        int unsigned    start_pos;

        if (element_pos >= MAX_ELEMENTS)
        begin
            // Past capacity the element is dropped but flagged.
            overflow_flag = 1'b1;
        end
        else
        begin
            pos = element_pos;
            prefix_sum = prefix_sum + value;
            if (prefix_sum == target_k && pos + 1 > longest)
                longest = pos + 1;
            // The lookup key is formed without wrapping.
            lookup_key = longint'(prefix_sum) - longint'(target_k);
            if (first_seen.exists(lookup_key))
            begin
                start_pos = first_seen[lookup_key];
                if (pos >= start_pos && pos - start_pos > longest)
                    longest = pos - start_pos;
            end
            // Only the first position of each prefix is kept.
            if (!first_seen.exists(longint'(prefix_sum)))
                first_seen[longint'(prefix_sum)] = pos;
            element_pos = pos + 1;
        end

        res.best     = longest[BEST_W-1:0];
        res.done     = last_flag;
        res.overflow = overflow_flag;

        // The final element closes the array and clears everything but the target.
        if (last_flag)
        begin
            prefix_sum    = '0;
            element_pos   = 0;
            longest       = 0;
            overflow_flag = 1'b0;
            first_seen.delete();
        end
        return res;
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] draw_element(input draw_mode_t mode);
        case (mode)
            DRAW_SMALL:  return VALUE_BITS'($urandom_range(0, 8) - 4);
            DRAW_MEDIUM: return VALUE_BITS'($urandom_range(0, 2000) - 1000);
            default:     return VALUE_BITS'($urandom);
        endcase
    endfunction

    // Offer one element beat, with an occasional gap in front, and record its result.
    task automatic send_element(
        input logic signed [VALUE_BITS-1:0] value,
        input bit                           last_flag
    );
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last_flag;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_lengths.push_back(predict_longest(value, last_flag));
    endtask

    // Stop sending and wait until every pending result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_lengths.size() != 0)
            @(posedge clk);
    endtask

    // Write the target only while the block is idle.
    task automatic write_target(input logic signed [SUM_W-1:0] k);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        target_k = k;
    endtask

    // Compare one accepted result beat with the oldest expectation.
    task automatic check_length_result();
        length_result_t want;

        if (expected_lengths.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: unexpected result beat, best_length %0d last %0b overflow %0b",
                         $time, m_axis_tdata[BEST_W-1:0], m_axis_tlast, m_axis_tuser[0]);
        end
        else
        begin
            want = expected_lengths.pop_front();
            if (m_axis_tdata[BEST_W-1:0] !== want.best)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: best_length expected %0d, actual %0d",
                             $time, want.best, m_axis_tdata[BEST_W-1:0]);
            end
            if (m_axis_tlast !== want.done)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: array_done expected %0b, actual %0b",
                             $time, want.done, m_axis_tlast);
            end
            if (m_axis_tuser[0] !== want.overflow)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: capacity_overflow expected %0b, actual %0b",
                             $time, want.overflow, m_axis_tuser[0]);
            end
        end
    endtask

    // Result side: check each beat and drive tready with random stalls and long holds.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_length_result();
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            stall_left = LONG_HOLD_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Short arrays with hand-picked sums, back to back so the clearing is checked.
    task automatic test_directed_sums();
        write_target(26'sd3);
        send_element(16'sd1, 1'b0);
        send_element(16'sd2, 1'b0);
        send_element(-16'sd1, 1'b0);
        send_element(16'sd1, 1'b0);
        send_element(16'sd3, 1'b0);
        send_element(-16'sd3, 1'b1);
        send_element(-16'sd32768, 1'b0);
        send_element(16'sd32767, 1'b0);
        send_element(16'sd1, 1'b0);
        send_element(16'sd3, 1'b1);
    endtask

    // Arrays of one element, matching and not matching the target.
    task automatic test_single_element_arrays();
        send_element(16'sd3, 1'b1);
        send_element(16'sd5, 1'b1);
    endtask

    // Both ends of the target range, then back to zero.
    task automatic test_target_extremes();
        write_target(-26'sd33554432);
        send_element(-16'sd32768, 1'b0);
        send_element(-16'sd32768, 1'b0);
        send_element(-16'sd32768, 1'b1);
        write_target(26'sd33554431);
        send_element(16'sd32767, 1'b0);
        send_element(16'sd32767, 1'b1);
        write_target(26'sd0);
        send_element(16'sd0, 1'b0);
        send_element(16'sd0, 1'b1);
    endtask

    // A full array whose whole sum is zero, then elements past capacity.
    task automatic test_capacity_overflow();
        int                          running;
        logic signed [VALUE_BITS-1:0] value;

        idle_enable <= 1'b1;
        write_target(26'sd0);
        running = 0;
        for (int i = 0; i < MAX_ELEMENTS - 1; i++)
        begin
            value = draw_element(DRAW_SMALL);
            running += value;
            send_element(value, 1'b0);
        end
        // Bring the total back to the target so the longest length is the whole array.
        value = VALUE_BITS'(-running);
        send_element(value, 1'b0);
        for (int i = 0; i < 3; i++)
            send_element(draw_element(DRAW_FULL), 1'b0);
        // The last element itself is ignored but still ends the array.
        send_element(draw_element(DRAW_FULL), 1'b1);
    endtask

    // The receiver holds off while results are flowing; the input must stall.
    task automatic test_output_backpressure();
        int sent;
        int len;

        hold_seq++;
        sent = 0;
        while (sent < 150)
        begin
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
                send_element(draw_element(DRAW_SMALL), i == len - 1);
            sent += len;
        end
    endtask

    // The sender pauses mid-array until every result is back, then goes on.
    task automatic test_pause_until_drained();
        for (int i = 0; i < 30; i++)
            send_element(draw_element(DRAW_SMALL), 1'b0);
        drain_results();
        for (int i = 0; i < 30; i++)
            send_element(draw_element(DRAW_SMALL), i == 29);
    endtask

    // Random arrays under one random target.
    task automatic test_random_arrays(input int item_count, input bit with_gaps);
        int                      sent;
        int                      len;
        int                      pick;
        draw_mode_t              mode;
        logic signed [SUM_W-1:0] k;

        idle_enable <= with_gaps;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            k = SUM_W'($urandom);
        else if (pick == 1)
            k = '0;
        else
            k = SUM_W'($urandom_range(0, 16) - 8);
        write_target(k);

        sent = 0;
        while (sent < item_count)
        begin
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                mode = DRAW_SMALL;
            else if (pick < 9)
                mode = DRAW_MEDIUM;
            else
                mode = DRAW_FULL;
            for (int i = 0; i < len; i++)
                send_element(draw_element(mode), i == len - 1);
            sent += len;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_sums();
        test_single_element_arrays();
        test_target_extremes();
        test_capacity_overflow();
        test_output_backpressure();
        test_pause_until_drained();
        for (int phase = 0; phase < 6; phase++)
            test_random_arrays(110, phase < 5);

        drain_results();
        repeat (LATENCY_CYCLES + 20) @(posedge clk);
        if (mismatch_count == 0 && expected_lengths.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== longest_subarray_sum_k_unit.f =====
hdl/lsk_pkg.sv
hdl/lsk_front.sv
hdl/lsk_cell.sv
hdl/lsk_back.sv
hdl/longest_subarray_sum_k_unit.sv
verif/longest_subarray_sum_k_unit_test.sv
